>>> sv/shift_queue_positional_insert_assert.svh
`ifndef SHIFT_QUEUE_POSITIONAL_INSERT_ASSERT_SVH
`define SHIFT_QUEUE_POSITIONAL_INSERT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define SQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that a condition implies a consequence in the next cycle.
`define SQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> sv/sqpi_pkg.sv
`default_nettype none

package sqpi_pkg;

    // Width of a cell mark: holds any slot index or count for DEPTH up to 64.
    localparam int MARK_W = 7;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_DUMP   = 2'd2,
        KIND_INSERT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_POSZERO = 3'd3,
        ST_PASTEND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ROTATE = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [MARK_W-1:0] mark;
    } t_cell_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] entry_payload;
        logic [4:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] read_payload;
        logic [3:0]  read_index;
        logic        last;
    } t_out_item;

endpackage

`default_nettype wire

>>> sv/shift_queue_positional_insert.sv
// Each result is loaded into the output register at the edge that accepts its item; a
// dump first enters the dump state, which loads its first entry once the output is free.
// Throughput: append, remove and insert are taken one per cycle, back to back, while the
// output register is free; a dump rotates its entries out of cell 0 one at a time.
// Reset (synchronous, active low) empties the queue and clears the handshake; the
// cells keep their contents, and only slots below the occupancy are ever read.
`default_nettype none

module shift_queue_positional_insert #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  sqpi_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output sqpi_pkg::t_out_item  o_out_item
);

`include "shift_queue_positional_insert_assert.svh"

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int MW    = sqpi_pkg::MARK_W;

    typedef enum logic {
        S_RUN,
        S_DUMP
    } t_state;

    t_state                 r_state, n_state;
    logic [OCC_W-1:0]       r_occ, n_occ;
    logic [IDX_W-1:0]       r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;
    sqpi_pkg::t_out_item    r_out_item, n_out_item;

    sqpi_pkg::t_cell_cmd    w_cmd;
    logic [PAYLOAD_BITS-1:0] w_data [DEPTH];
    logic [PAYLOAD_BITS-1:0] w_new;

    // widened copies of the count, the dump counter and the head entry
    logic [OCC_W+MW-1:0]        w_occ_wide;
    logic [IDX_W+MW-1:0]        w_cnt_wide;
    logic [IDX_W+3:0]           w_idx_wide;
    logic [PAYLOAD_BITS+63:0]   w_head_wide;
    logic [MW-1:0]              w_occ_m, w_cnt_m, w_pos_m;
    logic                       w_full, w_empty, w_out_free, w_accept, w_dump_last;

    assign w_occ_wide  = {{MW{1'b0}}, r_occ};
    assign w_cnt_wide  = {{MW{1'b0}}, r_cnt};
    assign w_idx_wide  = {4'b0, r_cnt};
    assign w_head_wide = {64'b0, w_data[0]};
    assign w_occ_m     = w_occ_wide[MW-1:0];
    assign w_cnt_m     = w_cnt_wide[MW-1:0];
    assign w_pos_m     = {2'b0, i_in_item.position};
    assign w_new       = i_in_item.entry_payload[PAYLOAD_BITS-1:0];

    assign w_full      = (r_occ == OCC_W'(DEPTH));
    assign w_empty     = (r_occ == '0);
    // the output register is free when empty or being drained this cycle
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_RUN) && w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_dump_last = (w_cnt_m == (w_occ_m - MW'(1)));

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        w_cmd.op    = sqpi_pkg::OP_HOLD;
        w_cmd.mark  = '0;

        if (r_state == S_DUMP) begin
            if (w_out_free) begin
                // emit the head, then rotate so the next entry reaches cell 0
                n_out_valid             = 1'b1;
                n_out_item.status       = sqpi_pkg::ST_OK;
                n_out_item.read_payload = w_head_wide[63:0];
                n_out_item.read_index   = w_idx_wide[3:0];
                n_out_item.last         = w_dump_last;
                w_cmd.op                = sqpi_pkg::OP_ROTATE;
                w_cmd.mark              = w_occ_m - MW'(1);
                if (w_dump_last) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
        end else if (w_accept) begin
            // single-result default; error cases override the status, and a dump clears the valid
            n_out_item.status       = sqpi_pkg::ST_OK;
            n_out_item.read_payload = '0;
            n_out_item.read_index   = '0;
            n_out_item.last         = 1'b1;
            n_out_valid             = 1'b1;
            case (sqpi_pkg::t_kind'(i_in_item.kind))
                sqpi_pkg::KIND_APPEND: begin
                    if (w_full) begin
                        n_out_item.status = sqpi_pkg::ST_FULL;
                    end else begin
                        // append is an insert at the tail slot
                        w_cmd.op   = sqpi_pkg::OP_INSERT;
                        w_cmd.mark = w_occ_m;
                        n_occ      = r_occ + OCC_W'(1);
                    end
                end
                sqpi_pkg::KIND_REMOVE: begin
                    if (w_empty) begin
                        n_out_item.status = sqpi_pkg::ST_EMPTY;
                    end else begin
                        w_cmd.op = sqpi_pkg::OP_REMOVE;
                        n_occ    = r_occ - OCC_W'(1);
                    end
                end
                sqpi_pkg::KIND_DUMP: begin
                    if (w_empty) begin
                        n_out_item.status = sqpi_pkg::ST_EMPTY;
                    end else begin
                        // no result yet: the entries follow from the dump state
                        n_out_valid = 1'b0;
                        n_state     = S_DUMP;
                        n_cnt       = '0;
                    end
                end
                sqpi_pkg::KIND_INSERT: begin
                    if (w_full) begin
                        n_out_item.status = sqpi_pkg::ST_FULL;
                    end else if (w_pos_m == '0) begin
                        n_out_item.status = sqpi_pkg::ST_POSZERO;
                    end else if (w_pos_m > (w_occ_m + MW'(1))) begin
                        n_out_item.status = sqpi_pkg::ST_PASTEND;
                    end else begin
                        w_cmd.op   = sqpi_pkg::OP_INSERT;
                        w_cmd.mark = w_pos_m - MW'(1);
                        n_occ      = r_occ + OCC_W'(1);
                    end
                end
                default: begin
                    n_out_item.status = sqpi_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_occ       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Row of storage cells; each sees its two neighbors, the head and the new entry.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sqpi_cell #(
            .IDX          (g),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_new   (w_new),
            .i_lower (w_data[(g == 0) ? 0 : g - 1]),
            .i_upper (w_data[(g == DEPTH - 1) ? g : g + 1]),
            .i_head  (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    `SQ_ASSERT_SAME(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= OCC_W'(DEPTH))
    `SQ_ASSERT_SAME(a_dump_nonempty, i_clk, i_rst_n, r_state == S_DUMP, !w_empty)
    `SQ_ASSERT_NEXT(a_dump_enter, i_clk, i_rst_n,
        w_accept && (i_in_item.kind == sqpi_pkg::KIND_DUMP) && !w_empty, r_state == S_DUMP)
    `SQ_ASSERT_SAME(a_nonlast_in_dump, i_clk, i_rst_n,
        o_out_valid && !o_out_item.last, r_state == S_DUMP)

endmodule

`default_nettype wire

>>> sv/sqpi_cell.sv
`default_nettype none

module sqpi_cell #(
    parameter int IDX          = 0,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire                        i_clk,
    input  sqpi_pkg::t_cell_cmd        i_cmd,
    input  wire [PAYLOAD_BITS-1:0]     i_new,
    input  wire [PAYLOAD_BITS-1:0]     i_lower,
    input  wire [PAYLOAD_BITS-1:0]     i_upper,
    input  wire [PAYLOAD_BITS-1:0]     i_head,
    output logic [PAYLOAD_BITS-1:0]    o_data
);

    localparam logic [sqpi_pkg::MARK_W-1:0] MY_IDX = sqpi_pkg::MARK_W'(IDX);

    logic [PAYLOAD_BITS-1:0] r_data;
    logic [PAYLOAD_BITS-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            sqpi_pkg::OP_INSERT: begin
                // open a gap at the mark: later cells take their lower neighbor
                if (MY_IDX > i_cmd.mark) begin
                    n_data = i_lower;
                end else if (MY_IDX == i_cmd.mark) begin
                    n_data = i_new;
                end
            end
            sqpi_pkg::OP_REMOVE: begin
                n_data = i_upper;
            end
            sqpi_pkg::OP_ROTATE: begin
                // circular shift over the occupied cells; the mark is the tail
                if (MY_IDX < i_cmd.mark) begin
                    n_data = i_upper;
                end else if (MY_IDX == i_cmd.mark) begin
                    n_data = i_head;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire
